/* src/cpfsk_pkg.sv */
`default_nettype none

package cpfsk_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELTA_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd2;

	localparam logic [15:0] AMPLITUDE_RESET = 16'd32768;

	// Q30 fixed point constants for the cosine table.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam longint      ONE_Q30     = 64'sd1073741824;

	// Taylor series denominators (2n-1)*(2n) for n = 1..8.
	localparam logic [63:0] TAYLOR_DIV [8] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
	};

	typedef logic signed [1:0] level_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_MUL_C,
		S_MUL_D,
		S_ROM,
		S_AMP,
		S_SCALE,
		S_FLUSH
	} cpfsk_state_t;

	// cos(pi/2 * m / 2^(abits-2)) in Q30, clamped to [-1, 1]. Used at elaboration only.
	function automatic longint quarter_cos(input int unsigned m, input int unsigned abits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (64'(m) * HALF_PI_Q30) >> (abits - 2);
		x2   = (x * x) >> 30;
		term = 64'(ONE_Q30);
		sum  = ONE_Q30;
		for (int n = 0; n < 8; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		if (sum < -ONE_Q30) begin
			sum = -ONE_Q30;
		end
		return sum;
	endfunction

endpackage

`default_nettype wire

/* src/cpfsk_ifs.sv */
`default_nettype none

interface cpfsk_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       message_start;

	modport source (output valid, output data_byte, output message_start, input ready);
	modport sink (input valid, input data_byte, input message_start, output ready);
endinterface

interface cpfsk_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last_of_byte;

	modport source (output valid, output sample, output last_of_byte, input ready);
	modport sink (input valid, input sample, input last_of_byte, output ready);
endinterface

`default_nettype wire

/* src/cpfsk_byte_modulator.sv */
`default_nettype none

// Channel   Direction  Payload                        Handshake
// bytes     in         data_byte, message_start       valid/ready
// samples   out        sample (s16), last_of_byte     valid/ready
// cfg       in         cfg_idx, cfg_wdata             cfg_we, no back-pressure
//
// One byte walks 8*TICKS_PER_BIT ticks, one tick per cycle between sample steps; every sample tick
// adds two phase products and a gain product on the shared 32x32 multiplier, a table read, a scale.
// Input ready is high only while idle; the last sample is held back until the byte ends.
// A full output register stalls the sequencer in the scale or flush step.
// Reset clears the tick index, the integral, both levels and the registers to their defaults.
module cpfsk_byte_modulator #(
	parameter int TICKS_PER_BIT   = 32,
	parameter int OVERSAMPLE      = 4,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cpfsk_in_if.sink                            bytes,
	cpfsk_out_if.source                         samples,
	input  logic                                cfg_we,
	input  logic [cpfsk_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [cpfsk_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import cpfsk_pkg::*;

	localparam int K_W     = $clog2(TICKS_PER_BIT);
	localparam int K_EXT   = K_W + 2;
	localparam int OS_W    = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
	localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
	localparam int R_W     = TABLE_ADDR_BITS - 2;
	localparam int Q_W     = TABLE_ADDR_BITS - 1;

	localparam logic [K_W-1:0]  K_LAST  = K_W'(TICKS_PER_BIT - 1);
	localparam logic [OS_W-1:0] OS_LAST = OS_W'(OVERSAMPLE - 1);

	// Quarter-wave cosine table, entries 0..QUARTER.
	logic signed [31:0] cos_rom [QUARTER+1];

	for (genvar m = 0; m <= QUARTER; m++) begin : g_rom
		assign cos_rom[m] = 32'(quarter_cos(m, TABLE_ADDR_BITS));
	end

	cpfsk_state_t state_q, state_d;

	logic [31:0]        center_q, delta_q;
	logic [15:0]        amp_q;
	logic [7:0]         byte_q;
	logic               start_q;
	logic [2:0]         j_q;
	logic [K_W-1:0]     k_q;
	logic               done_q;
	logic [31:0]        tick_q;
	logic [OS_W-1:0]    os_q;
	logic [31:0]        integral_q;
	level_t             cur_q, prev_q;
	logic [31:0]        smp_tick_q;
	logic [31:0]        phase_q;
	logic signed [31:0] c_q;
	logic [46:0]        amp_prod_q;
	logic               pend_valid_q;
	logic [15:0]        pend_q;
	logic               out_valid_q;
	logic [15:0]        out_sample_q;
	logic               out_last_q;

	// Tick decode.
	logic               skip;
	logic               smp_tick;
	logic               last_tick;
	level_t             bit_lvl;
	level_t             new_cur;
	logic [OS_W-1:0]    os_next;

	always_comb begin
		skip      = start_q && (j_q == 3'd0) && (K_EXT'(k_q) < K_EXT'(2));
		smp_tick  = !skip && (os_q == '0);
		last_tick = (j_q == 3'd7) && (k_q == K_LAST);
		bit_lvl   = byte_q[3'd7 - j_q] ? 2'sb11 : 2'sb01;
		new_cur   = (k_q == '0) ? bit_lvl : cur_q;
		// The tick counter wraps at 2^32, which restarts the oversample phase too.
		os_next   = ((os_q == OS_LAST) || (tick_q == '1)) ? '0 : os_q + 1'b1;
	end

	// Table address with quarter-wave folding.
	logic [1:0]     quad;
	logic [R_W-1:0] rem;
	logic [Q_W-1:0] rom_idx;
	logic           rom_flip;

	always_comb begin
		quad     = phase_q[31:30];
		rem      = phase_q[29 -: R_W];
		rom_idx  = quad[0] ? (Q_W'(QUARTER) - {1'b0, rem}) : {1'b0, rem};
		rom_flip = quad[1] ^ quad[0];
	end

	// Shared multiplier.
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [31:0] c_abs;

	assign c_abs = c_q[31] ? (~c_q + 32'd1) : c_q;
	assign mul_p = mul_a * mul_b;

	// Gain scaling: v = (mag*amp*32767) >> 45, then saturate by sign.
	logic [61:0] scaled;
	logic [16:0] mag_v;
	logic [15:0] sample_new;

	always_comb begin
		scaled = {amp_prod_q, 15'd0} - {15'd0, amp_prod_q};
		mag_v  = scaled[61:45];
		if (c_q[31]) begin
			if (mag_v > 17'd32768) begin
				sample_new = 16'h8000;
			end else begin
				sample_new = 16'(17'h10000 - mag_v);
			end
		end else if (mag_v > 17'd32767) begin
			sample_new = 16'h7FFF;
		end else begin
			sample_new = mag_v[15:0];
		end
	end

	// Sequencer outputs.
	logic in_ready;
	logic slot_free;
	logic scale_go;
	logic push_en;
	logic push_last;

	always_comb begin
		in_ready  = 1'b0;
		scale_go  = 1'b0;
		push_en   = 1'b0;
		push_last = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		slot_free = !out_valid_q || samples.ready;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_MUL_C: begin
				mul_a = center_q;
				mul_b = smp_tick_q;
			end
			S_MUL_D: begin
				mul_a = delta_q;
				mul_b = integral_q;
			end
			S_AMP: begin
				mul_a = c_abs;
				mul_b = {16'd0, amp_q};
			end
			S_SCALE: begin
				scale_go = !pend_valid_q || slot_free;
				push_en  = pend_valid_q && slot_free;
			end
			S_FLUSH: begin
				push_en   = pend_valid_q && slot_free;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (bytes.valid) begin
					state_d = S_TICK;
				end
			end
			S_TICK: begin
				if (smp_tick) begin
					state_d = S_MUL_C;
				end else if (last_tick) begin
					state_d = S_FLUSH;
				end
			end
			S_MUL_C: state_d = S_MUL_D;
			S_MUL_D: state_d = S_ROM;
			S_ROM:   state_d = S_AMP;
			S_AMP:   state_d = S_SCALE;
			S_SCALE: begin
				if (scale_go) begin
					state_d = done_q ? S_FLUSH : S_TICK;
				end
			end
			S_FLUSH: begin
				if (!pend_valid_q || slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			delta_q  <= '0;
			amp_q    <= AMPLITUDE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_CENTER_STEP: center_q <= cfg_wdata;
				CFG_DELTA_STEP:  delta_q  <= cfg_wdata;
				CFG_AMPLITUDE:   amp_q    <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Modulator state and byte walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			os_q       <= '0;
			integral_q <= '0;
			cur_q      <= '0;
			prev_q     <= '0;
			j_q        <= '0;
			k_q        <= '0;
			done_q     <= 1'b0;
			start_q    <= 1'b0;
		end else if (state_q == S_IDLE) begin
			if (bytes.valid) begin
				j_q     <= '0;
				k_q     <= '0;
				done_q  <= 1'b0;
				start_q <= bytes.message_start;
				if (bytes.message_start) begin
					tick_q <= '0;
					os_q   <= '0;
					cur_q  <= bytes.data_byte[7] ? 2'sb11 : 2'sb01;
				end
			end
		end else if (state_q == S_TICK) begin
			tick_q <= tick_q + 32'd1;
			os_q   <= os_next;
			if (!skip) begin
				prev_q <= cur_q;
				cur_q  <= new_cur;
				if (new_cur == cur_q) begin
					integral_q <= integral_q + {{30{new_cur[1]}}, new_cur};
				end
			end
			if (k_q == K_LAST) begin
				k_q <= '0;
				j_q <= j_q + 3'd1;
			end else begin
				k_q <= k_q + 1'b1;
			end
			if (last_tick) begin
				done_q <= 1'b1;
			end
		end
	end

	// Sample datapath.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && bytes.valid) begin
			byte_q <= bytes.data_byte;
		end
		if (state_q == S_TICK && smp_tick) begin
			smp_tick_q <= tick_q;
		end
		if (state_q == S_MUL_C) begin
			phase_q <= mul_p[31:0];
		end
		if (state_q == S_MUL_D) begin
			phase_q <= phase_q + mul_p[31:0];
		end
		if (state_q == S_ROM) begin
			c_q <= rom_flip ? -cos_rom[rom_idx] : cos_rom[rom_idx];
		end
		if (state_q == S_AMP) begin
			amp_prod_q <= mul_p[46:0];
		end
		if (scale_go) begin
			pend_q <= sample_new;
		end
	end

	// The newest sample waits in the pending register until the next one or the byte end
	// decides whether it is the last of its byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (scale_go) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == S_FLUSH && push_en) begin
				pend_valid_q <= 1'b0;
			end
			if (push_en) begin
				out_valid_q <= 1'b1;
			end else if (samples.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			out_sample_q <= pend_q;
			out_last_q   <= push_last;
		end
	end

	assign bytes.ready          = in_ready;
	assign samples.valid        = out_valid_q;
	assign samples.sample       = out_sample_q;
	assign samples.last_of_byte = out_last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("pending sample left over while idle");

	a_integral_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_TICK) |=> $stable(integral_q))
		else $error("integral changed outside a tick");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH && pend_valid_q && slot_free) |=>
		(out_valid_q && out_last_q && state_q == S_IDLE))
		else $error("byte end did not emit a last sample");

	a_phase_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL_C) |=> (state_q == S_MUL_D))
		else $error("phase products out of order");

	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != 2'sb10) && (prev_q != 2'sb10))
		else $error("invalid level code");

endmodule

`default_nettype wire
